// File: rtl/stk_pkg.sv
// Shared types and constants for the streaming top-k select block.
// Used by stk_ctrl, stk_datapath and streaming_top_k_select; no dependencies.

package stk_pkg;

	// Number of kept values and field widths
	localparam int MAX_RANK = 16;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = $clog2(MAX_RANK + 1);
	localparam int IDX_W    = $clog2(MAX_RANK);
	localparam int RANK_W   = 5;

	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [RANK_W-1:0]        rank_t;
	typedef logic signed [VAL_W-1:0]  val_t;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;   // insert the incoming word into the kept set
		logic emit;   // incoming word closes the set: latch result, clear set
	} cmd_t;

endpackage

// File: rtl/stk_ctrl.sv
// Controller for the streaming top-k select block: input/output handshake FSM.
// Depends on stk_pkg.

module stk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	input  logic          m_tready,
	output logic          s_tready,
	output logic          m_tvalid,
	output stk_pkg::cmd_t cmd
);

	stk_pkg::state_t state_q;
	stk_pkg::state_t state_d;
	logic            in_rdy;

	// Accept a word when the result register is empty or draining this cycle
	always_comb begin
		in_rdy   = (state_q == stk_pkg::ST_EMPTY) || m_tready;
		cmd.take = s_tvalid && in_rdy;
		cmd.emit = s_tvalid && in_rdy && s_tlast;
	end

	// Advance the result-register state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stk_pkg::ST_EMPTY: begin
				if (cmd.emit)
					state_d = stk_pkg::ST_FULL;
			end
			stk_pkg::ST_FULL: begin
				if (cmd.emit)
					state_d = stk_pkg::ST_FULL;
				else if (m_tready)
					state_d = stk_pkg::ST_EMPTY;
			end
			default: state_d = stk_pkg::ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= stk_pkg::ST_EMPTY;
		else
			state_q <= state_d;
	end

	assign s_tready = in_rdy;
	assign m_tvalid = (state_q == stk_pkg::ST_FULL);

endmodule

// File: rtl/stk_datapath.sv
// Datapath for the streaming top-k select block: rank register, sorted kept
// set with parallel insertion, and result register. Depends on stk_pkg.

module stk_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  stk_pkg::cmd_t  cmd,
	input  logic           cfg_valid,
	input  stk_pkg::rank_t cfg_data,
	input  stk_pkg::val_t  in_value,
	output stk_pkg::val_t  kth_value,
	output logic           too_few
);

	stk_pkg::rank_t rank_q;
	stk_pkg::cnt_t  k_eff;
	stk_pkg::cnt_t  cnt_q;
	stk_pkg::cnt_t  cnt_cur;
	stk_pkg::cnt_t  cnt_new;
	stk_pkg::cnt_t  last_pos;
	stk_pkg::val_t  kept_q   [stk_pkg::MAX_RANK];
	stk_pkg::val_t  kept_new [stk_pkg::MAX_RANK];
	logic [stk_pkg::MAX_RANK-1:0] ge;
	stk_pkg::val_t  res_value;
	logic           res_few;
	stk_pkg::val_t  kth_q;
	logic           few_q;

	// Hold the rank register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rank_q <= stk_pkg::rank_t'(1);
		else if (cfg_valid)
			rank_q <= cfg_data;
	end

	// Clamp k to 1..MAX_RANK
	always_comb begin
		if (rank_q == '0)
			k_eff = stk_pkg::cnt_t'(1);
		else if (stk_pkg::CNT_W'(rank_q) > stk_pkg::cnt_t'(stk_pkg::MAX_RANK))
			k_eff = stk_pkg::cnt_t'(stk_pkg::MAX_RANK);
		else
			k_eff = stk_pkg::cnt_t'(rank_q);
	end

	// Insert the word: entries not below it stay, the rest shift down one place
	always_comb begin
		cnt_cur = (cnt_q > k_eff) ? k_eff : cnt_q;
		for (int i = 0; i < stk_pkg::MAX_RANK; i++)
			ge[i] = (stk_pkg::cnt_t'(i) < cnt_cur) && (kept_q[i] >= in_value);
		for (int i = 0; i < stk_pkg::MAX_RANK; i++) begin
			if (ge[i])
				kept_new[i] = kept_q[i];
			else if (i == 0)
				kept_new[i] = in_value;
			else if (ge[i-1])
				kept_new[i] = in_value;
			else
				kept_new[i] = kept_q[i-1];
		end
		// A full set drops its smallest entry
		cnt_new   = (cnt_cur == k_eff) ? cnt_cur : cnt_cur + stk_pkg::cnt_t'(1);
		last_pos  = cnt_new - stk_pkg::cnt_t'(1);
		res_value = kept_new[last_pos[stk_pkg::IDX_W-1:0]];
		res_few   = cnt_new < k_eff;
	end

	// Update the kept count; clear it when a set closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.emit)
			cnt_q <= '0;
		else if (cmd.take)
			cnt_q <= cnt_new;
	end

	// Hold the kept values
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int i = 0; i < stk_pkg::MAX_RANK; i++)
				kept_q[i] <= kept_new[i];
		end
	end

	// Latch the result word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kth_q <= res_value;
			few_q <= res_few;
		end
	end

	assign kth_value = kth_q;
	assign too_few   = few_q;

endmodule

// File: rtl/streaming_top_k_select.sv
// Streaming top-k select: reports the k-th largest value of each data set.
// Top level; instantiates stk_ctrl and stk_datapath, depends on stk_pkg.
//
// Usage:
//   Input words arrive on the s_ channel, one signed 32-bit value per word,
//   s_tlast high on the final value of a set. The cfg channel writes k
//   (rank_k, 1..16; 0 acts as 1, above 16 as 16); cfg_ready is always high.
//   Write k only between words; a change mid-set applies from the next word.
//   On the last word of a set one result word appears on the m_ channel:
//   tdata holds the k-th largest value, tuser is high when the set held
//   fewer than k values (tdata then holds the smallest value of the set).
//   Throughput: one input word per cycle unless a held result stalls input.
//   The kept set is a sorted register row updated by one parallel compare-and-shift.
//   Latency: the result is valid the cycle after the last word is taken.
//   When the receiver stalls, the result waits in the output register and
//   every input word is held off, whether it closes a set or not:
//   s_tready drops while a result is held and m_tready is low.
//   Reset clears the kept count, the output valid and sets k to 1.

module streaming_top_k_select (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,    // [4:0] rank_k
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // [31:0] value
	input  logic        s_tlast,     // last
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [31:0] kth_value
	output logic        m_tuser      // [0] too_few
);

	stk_pkg::cmd_t cmd;
	stk_pkg::val_t kth_value;

	assign cfg_ready = 1'b1;

	stk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	stk_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_value  (s_tdata),
		.kth_value (kth_value),
		.too_few   (m_tuser)
	);

	assign m_tdata = kth_value;

endmodule

// File: sim/stk_checker.sv
// Checker for the streaming top-k select block: watches the config, input and result channels.
// Predicts the k-th largest value of each set and compares results; depends on stk_pkg.

module stk_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	typedef struct {
		stk_pkg::val_t kth;
		logic          few;
	} kth_rec_t;

	// Predicted kept set, largest first, and the rank in force
	stk_pkg::val_t  kept_row [stk_pkg::MAX_RANK];
	int unsigned    kept_n;
	stk_pkg::rank_t rank_reg;
	kth_rec_t       kth_expected [$];

	// Take one word into the predicted kept set; close the set on last
	function automatic void admit_value(stk_pkg::val_t v, logic lst);
		int unsigned k;
		int unsigned pos;
		bit          skip;
		kth_rec_t    rec;
		if (rank_reg == 0)
			k = 1;
		else if (rank_reg > stk_pkg::MAX_RANK)
			k = stk_pkg::MAX_RANK;
		else
			k = rank_reg;
		skip = 1'b0;
		// trim after a rank drop in mid-set
		if (kept_n > k)
			kept_n = k;
		if (kept_n < k) begin
			pos = kept_n;
			kept_n++;
		end else if (v <= kept_row[kept_n-1]) begin
			skip = 1'b1;
			pos = 0;
		end else begin
			pos = kept_n - 1;
		end
		if (!skip) begin
			while (pos > 0 && kept_row[pos-1] < v) begin
				kept_row[pos] = kept_row[pos-1];
				pos--;
			end
			kept_row[pos] = v;
		end
		if (lst) begin
			rec.kth = kept_row[kept_n-1];
			rec.few = (kept_n < k);
			kth_expected.push_back(rec);
			kept_n = 0;
		end
	endfunction

	// Sample every channel at the rising edge
	always @(posedge clk or negedge arst_n) begin
		kth_rec_t want;
		if (!arst_n) begin
			kept_n = 0;
			rank_reg = 1;
			kth_expected.delete();
			fail_count = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			// compare a result word with the oldest prediction
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (kth_expected.size() == 0) begin
					$error("unexpected result word: kth_value %0d, too_few %0b",
						$signed(m_tdata), m_tuser);
					fail_count++;
				end else begin
					want = kth_expected.pop_front();
					if (m_tdata !== want.kth) begin
						$error("kth_value mismatch: expected %0d, actual %0d",
							want.kth, $signed(m_tdata));
						fail_count++;
					end
					if (m_tuser !== want.few) begin
						$error("too_few mismatch: expected %0b, actual %0b",
							want.few, m_tuser);
						fail_count++;
					end
				end
			end
			// a word taken at the same edge as a rank write still sees the old rank
			if (s_tvalid && s_tready)
				admit_value(s_tdata, s_tlast);
			if (cfg_valid && cfg_ready)
				rank_reg = cfg_data;
			pending = kth_expected.size();
		end
	end

endmodule

// File: sim/streaming_top_k_select_tb.sv
// Testbench top for streaming_top_k_select: clock, reset, stimulus and verdict.
// Depends on stk_pkg, the block itself and stk_checker, which does all checking.

module streaming_top_k_select_tb;

	localparam int QUIET_LIMIT  = 3000;
	localparam int RANDOM_WORDS = 650;
	localparam int IDLE_PCT     = 11;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;     // [31:0] value
	logic        s_tlast;     // last
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;     // [31:0] kth_value
	logic        m_tuser;     // [0] too_few

	int fail_count;
	int pending;
	int results_seen;
	int words_sent;
	int sets_sent;
	int ranks_written;
	int quiet;
	bit calm;

	streaming_top_k_select u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	stk_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: stall at random unless in a calm stretch
	initial begin
		forever begin
			@(negedge clk);
			m_tready <= !(!calm && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Stop a hung run: count cycles in which no word moves
	initial begin
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no word accepted for %0d cycles", QUIET_LIMIT);
				$display("** streaming_top_k_select: FAILED **");
				$finish;
			end
		end
	end

	// Offer one input word, with random gaps before it; return at the next falling edge
	task automatic send_word(stk_pkg::val_t v, logic lst);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		if (lst)
			sets_sent++;
		@(negedge clk);
	endtask

	// Write rank_k once the block has drained
	task automatic write_rank(stk_pkg::rank_t k);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ranks_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mix of extremes, tightly clustered values (many ties) and full-range values
	function automatic stk_pkg::val_t pick_value();
		unique case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3, 4: return $signed($urandom_range(10)) - 5;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(int n);
		for (int i = 1; i <= n; i++)
			send_word(pick_value(), i == n);
	endtask

	initial begin
		int   phase_words;
		int   len;
		int   pick;
		stk_pkg::rank_t k;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		calm      = 1'b0;
		words_sent = 0;
		sets_sent = 0;
		ranks_written = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: rank 1 from reset, single-word sets at the value extremes
		send_word(32'sh7FFF_FFFF, 1'b1);
		send_word(32'sh8000_0000, 1'b1);
		// Rank 16 with a short set: too few values, smallest reported
		write_rank(5'd16);
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sd0, 1'b0);
		send_word(-32'sd1, 1'b1);
		// Rank zero acts as one
		write_rank(5'd0);
		send_word(32'sd5, 1'b0);
		send_word(-32'sd3, 1'b0);
		send_word(32'sd9, 1'b1);
		// Rank above the maximum saturates
		write_rank(5'd31);
		send_word(32'sd1, 1'b0);
		send_word(32'sd2, 1'b1);
		// Equal values with a full kept set
		write_rank(5'd3);
		send_word(32'sd7, 1'b0);
		send_word(32'sd7, 1'b0);
		send_word(32'sd7, 1'b0);
		send_word(32'sd7, 1'b1);
		// Rank lowered in mid-set: smallest kept values are dropped
		send_word(32'sd10, 1'b0);
		send_word(32'sd20, 1'b0);
		send_word(32'sd30, 1'b0);
		send_word(32'sd40, 1'b0);
		write_rank(5'd2);
		send_word(32'sd5, 1'b1);
		// Rank raised in mid-set
		send_word(32'sd50, 1'b0);
		write_rank(5'd4);
		send_word(32'sd60, 1'b1);

		// Random: phases of well-formed sets under random ranks
		words_sent = 0;
		sets_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			pick = $urandom_range(19);
			unique case (pick)
				17: k = 5'd17;
				18: k = 5'd31;
				19: k = 5'd16;
				default: k = stk_pkg::rank_t'(pick);
			endcase
			write_rank(k);
			phase_words = 0;
			while (phase_words < 50) begin
				// one calm stretch in the middle of the run
				calm = (words_sent >= 250 && words_sent < 400);
				if ($urandom_range(9) == 0)
					len = $urandom_range(17, 40);
				else
					len = $urandom_range(1, 20);
				send_set(len);
				phase_words += len;
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// Drain and let the output settle
		while (pending != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);

		$display("Covered %0d random words in %0d sets after the directed cases,",
			words_sent, sets_sent);
		$display("with %0d rank writes; %0d result words compared.",
			ranks_written, results_seen);
		if (fail_count == 0)
			$display("** streaming_top_k_select: PASSED **");
		else
			$display("** streaming_top_k_select: FAILED **");
		$finish;
	end

endmodule
